>>> src/ipv4_pkg.sv
// Shared types and character classes for the IPv4 dotted address parser.
`default_nettype none

package ipv4_pkg;

	// Parser phase within the current part
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_ZERO   = 3'd1,
		PH_DIGITS = 3'd2,
		PH_TRAIL  = 3'd3,
		PH_ERROR  = 3'd4
	} phase_t;

	// Number base of the current part
	typedef enum logic [1:0] {
		RX_DEC = 2'd0,
		RX_OCT = 2'd1,
		RX_HEX = 2'd2
	} radix_t;

	localparam logic [7:0]  CH_TERM   = 8'h00;
	localparam logic [7:0]  CH_ZERO   = 8'h30;
	localparam logic [7:0]  CH_DOT    = 8'h2E;
	localparam logic [7:0]  CH_X_LO   = 8'h78;
	localparam logic [7:0]  CH_X_UP   = 8'h58;
	localparam logic [1:0]  MAX_SAVED = 2'd3;

	localparam logic [31:0] LIM_TWO   = 32'h00ff_ffff;
	localparam logic [31:0] LIM_THREE = 32'h0000_ffff;
	localparam logic [31:0] LIM_FOUR  = 32'h0000_00ff;

	// Decimal digit '0'..'9'
	function automatic logic is_dec(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	// Space, tab, newline, vertical tab, form feed, carriage return
	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'h09:8'h0D]});
	endfunction

	// Hex letter a..f or A..F
	function automatic logic is_hex_letter(input logic [7:0] c);
		return (c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]});
	endfunction

	// Value of a hex letter; low three bits of a..f / A..F map 1..6 to 10..15
	function automatic logic [3:0] hex_letter_val(input logic [7:0] c);
		return 4'd9 + {1'b0, c[2:0]};
	endfunction

endpackage

`default_nettype wire

>>> src/ipv4_dotted_address_parser_unit.sv
// IPv4 dotted address parser: character input register, parse state, result register.
`default_nettype none

// Takes the text of an IPv4 address one character per transaction and,
// on the zero terminator, delivers one transaction holding ok and the
// 32-bit address in host order (address is zero when ok is low). Other
// characters deliver nothing. Parts may be decimal, octal (leading 0) or
// hex (0x prefix); one to four parts are accepted, the last one range
// checked. A character is accepted every cycle: it is captured in an
// input register, the parse state is updated by one short step of logic
// (a shift-add by the base) on the next edge, and the result lands in an
// output register. The terminator goes through the input register and then
// into the result register when that is free; the input stalls only while a
// finished result waits and a new terminator needs the output register.
module ipv4_dotted_address_parser_unit
	import ipv4_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  char_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             ok,
	output logic [31:0]      address
);

	logic        valid_s1;
	logic [7:0]  char_s1;

	phase_t      phase_q, phase_d;
	radix_t      radix_q, radix_d;
	logic [31:0] part_q, part_d;
	logic [1:0]  count_q, count_d;
	logic [31:0] saved_q [3];
	logic        save_en;

	logic        out_valid_q;
	logic        ok_q;
	logic [31:0] address_q;

	logic        is_term;
	logic        out_free;
	logic        step;
	logic        ok_d;
	logic [31:0] addr_d;

	radix_t      eff_radix;
	logic [31:0] scaled;
	logic [31:0] dec_next;
	logic [31:0] hex_next;

	assign is_term  = (char_s1 == CH_TERM);
	assign out_free = !out_valid_q || !out_stall;
	assign step     = valid_s1 && (!is_term || out_free);
	assign in_stall = valid_s1 && !step;

	// Capture the incoming character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1 <= char_in;
		end
	end

	// Shift-add of the accumulator by the base of the current part
	always_comb begin
		eff_radix = (phase_q == PH_ZERO) ? RX_OCT : radix_q;
		case (eff_radix)
			RX_HEX:  scaled = {part_q[27:0], 4'b0000};
			RX_OCT:  scaled = {part_q[28:0], 3'b000};
			default: scaled = {part_q[28:0], 3'b000} + {part_q[30:0], 1'b0};
		endcase
		dec_next = scaled + {28'd0, char_s1[3:0]};
		hex_next = {part_q[27:0], hex_letter_val(char_s1)};
	end

	// Next parse state
	always_comb begin
		phase_d = phase_q;
		radix_d = radix_q;
		part_d  = part_q;
		count_d = count_q;
		save_en = 1'b0;
		if (is_term) begin
			phase_d = PH_START;
			radix_d = RX_DEC;
			part_d  = '0;
			count_d = '0;
		end else begin
			case (phase_q)
				PH_START: begin
					if (!is_dec(char_s1)) begin
						phase_d = PH_ERROR;
					end else if (char_s1 == CH_ZERO) begin
						part_d  = '0;
						radix_d = RX_OCT;
						phase_d = PH_ZERO;
					end else begin
						part_d  = {28'd0, char_s1[3:0]};
						radix_d = RX_DEC;
						phase_d = PH_DIGITS;
					end
				end
				PH_ZERO, PH_DIGITS: begin
					if (phase_q == PH_ZERO) begin
						radix_d = RX_OCT;
					end
					if (phase_q == PH_ZERO && (char_s1 == CH_X_LO || char_s1 == CH_X_UP)) begin
						radix_d = RX_HEX;
						phase_d = PH_DIGITS;
					end else if (is_dec(char_s1)) begin
						part_d  = dec_next;
						phase_d = PH_DIGITS;
					end else if (eff_radix == RX_HEX && is_hex_letter(char_s1)) begin
						part_d  = hex_next;
						phase_d = PH_DIGITS;
					end else if (char_s1 == CH_DOT) begin
						if (count_q == MAX_SAVED) begin
							phase_d = PH_ERROR;
						end else begin
							save_en = 1'b1;
							count_d = count_q + 2'd1;
							part_d  = '0;
							radix_d = RX_DEC;
							phase_d = PH_START;
						end
					end else if (is_space(char_s1)) begin
						phase_d = PH_TRAIL;
					end else begin
						phase_d = PH_ERROR;
					end
				end
				PH_TRAIL: begin
					phase_d = PH_TRAIL;
				end
				default: begin
					phase_d = PH_ERROR;
				end
			endcase
		end
	end

	// Assemble the address and range check the last part
	always_comb begin
		ok_d   = 1'b0;
		addr_d = '0;
		if (phase_q != PH_START && phase_q != PH_ERROR) begin
			case (count_q)
				2'd0: begin
					ok_d   = 1'b1;
					addr_d = part_q;
				end
				2'd1: begin
					ok_d   = (part_q <= LIM_TWO);
					addr_d = part_q | {saved_q[0][7:0], 24'd0};
				end
				2'd2: begin
					ok_d   = (part_q <= LIM_THREE);
					addr_d = part_q | {saved_q[0][7:0], 24'd0} | {saved_q[1][15:0], 16'd0};
				end
				default: begin
					ok_d   = (part_q <= LIM_FOUR);
					addr_d = part_q | {saved_q[0][7:0], 24'd0} | {saved_q[1][15:0], 16'd0}
						| {saved_q[2][23:0], 8'd0};
				end
			endcase
			if (!ok_d) begin
				addr_d = '0;
			end
		end
	end

	// Advance the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			radix_q <= RX_DEC;
			part_q  <= '0;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			part_q  <= part_d;
			count_q <= count_d;
		end
	end

	// Hold finished parts before the last
	always_ff @(posedge clk) begin
		if (step && save_en) begin
			saved_q[count_q] <= part_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_term) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_term) begin
			ok_q      <= ok_d;
			address_q <= addr_d;
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign address   = address_q;

endmodule

`default_nettype wire
